[rtl/spike_trace_linear_readout_top_assert.svh]
// assertion macros for the spike trace readout block
// used by the controller; no dependencies
`ifndef SPIKE_TRACE_LINEAR_READOUT_TOP_ASSERT_SVH
`define SPIKE_TRACE_LINEAR_READOUT_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define STLR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("stlr assertion failed");
`define STLR_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("stlr reset assertion failed");
`else
`define STLR_ASSERT(lbl, prop)
`define STLR_ASSERT_RST(lbl, prop)
`endif

`endif

[rtl/stlr_pkg.sv]
// shared types and constants for the spike trace readout block
// no dependencies
package stlr_pkg;

    localparam int IDX_W   = 6;
    localparam int CLR_W   = 12;
    localparam int TRACE_W = 24;
    localparam int WGT_W   = 16;
    localparam int SUM_W   = 48;
    localparam int CFG_W   = 24;

    localparam logic [15:0]      DECAY_RESET = 16'd63380;
    localparam logic [CFG_W-1:0] INC_RESET   = 24'd65536;
    localparam logic [TRACE_W-1:0] TRACE_MAX = 24'hFFFFFF;

    typedef enum logic [1:0] {
        OP_SPIKE  = 2'd0,
        OP_TICK   = 2'd1,
        OP_READ   = 2'd2,
        OP_WWRITE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_DECAY = 2'd0,
        CFG_INC   = 2'd1
    } t_cfg;

    typedef enum logic [1:0] {
        M_SPIKE = 2'd0,
        M_TICK  = 2'd1,
        M_READ  = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SPIKE,
        S_TICK,
        S_SWEEP,
        S_DRAIN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic             latch;
        logic             wwrite;
        logic             clr_we;
        logic [CLR_W-1:0] clr_addr;
        logic             tr_rd;
        logic             wt_rd;
        t_mode            mode;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] ch;
        logic             emit;
        logic             emit_last;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

[rtl/stlr_ram.sv]
// generic single write, single read ram with registered read
// no dependencies
module stlr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [$clog2(DEPTH)-1:0]       i_waddr,
    input  logic [WIDTH-1:0]               i_wdata,
    input  logic                           i_re,
    input  logic [$clog2(DEPTH)-1:0]       i_raddr,
    output logic [WIDTH-1:0]               o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/stlr_ctrl.sv]
// sequencer for the spike trace readout block
// depends on stlr_pkg and spike_trace_linear_readout_top_assert.svh
`include "spike_trace_linear_readout_top_assert.svh"

module stlr_ctrl #(
    parameter int NUM_INPUTS   = 64,
    parameter int NUM_CHANNELS = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [1:0]    i_op,
    output logic          o_in_stall,
    input  stlr_pkg::t_sts i_sts,
    output stlr_pkg::t_cmd o_cmd
);

    localparam int NI_W = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
    localparam int NC_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int AW   = NI_W + NC_W;
    localparam logic [NI_W-1:0] LAST_IDX = NI_W'(NUM_INPUTS - 1);
    localparam logic [NC_W-1:0] LAST_CH  = NC_W'(NUM_CHANNELS - 1);

    stlr_pkg::t_state r_state, n_state;
    logic [AW-1:0]    r_clr;
    logic [NI_W-1:0]  r_idx;
    logic [NC_W-1:0]  r_ch;
    logic             r_drain;
    logic             w_accept;

    assign o_in_stall = (r_state != stlr_pkg::S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            stlr_pkg::S_CLEAR: begin
                if (r_clr == '1) n_state = stlr_pkg::S_IDLE;
            end
            stlr_pkg::S_IDLE: begin
                if (w_accept) begin
                    case (i_op)
                        stlr_pkg::OP_SPIKE: n_state = stlr_pkg::S_SPIKE;
                        stlr_pkg::OP_TICK:  n_state = stlr_pkg::S_TICK;
                        stlr_pkg::OP_READ:  n_state = stlr_pkg::S_SWEEP;
                        default:            n_state = stlr_pkg::S_IDLE;
                    endcase
                end
            end
            stlr_pkg::S_SPIKE: n_state = stlr_pkg::S_IDLE;
            stlr_pkg::S_TICK: begin
                if (r_idx == LAST_IDX) n_state = stlr_pkg::S_IDLE;
            end
            stlr_pkg::S_SWEEP: begin
                if (r_idx == LAST_IDX) n_state = stlr_pkg::S_DRAIN;
            end
            stlr_pkg::S_DRAIN: begin
                if (r_drain) n_state = stlr_pkg::S_EMIT;
            end
            stlr_pkg::S_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = (r_ch == LAST_CH) ? stlr_pkg::S_IDLE : stlr_pkg::S_SWEEP;
                end
            end
            default: n_state = stlr_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.mode     = stlr_pkg::M_SPIKE;
        o_cmd.latch    = w_accept;
        o_cmd.wwrite   = w_accept && (i_op == stlr_pkg::OP_WWRITE);
        o_cmd.clr_addr = stlr_pkg::CLR_W'(r_clr);
        o_cmd.idx      = stlr_pkg::IDX_W'(r_idx);
        o_cmd.ch       = stlr_pkg::IDX_W'(r_ch);
        case (r_state)
            stlr_pkg::S_CLEAR: o_cmd.clr_we = 1'b1;
            stlr_pkg::S_SPIKE: begin
                o_cmd.tr_rd = 1'b1;
                o_cmd.mode  = stlr_pkg::M_SPIKE;
            end
            stlr_pkg::S_TICK: begin
                o_cmd.tr_rd = 1'b1;
                o_cmd.mode  = stlr_pkg::M_TICK;
            end
            stlr_pkg::S_SWEEP: begin
                o_cmd.tr_rd = 1'b1;
                o_cmd.wt_rd = 1'b1;
                o_cmd.mode  = stlr_pkg::M_READ;
            end
            stlr_pkg::S_EMIT: begin
                o_cmd.mode      = stlr_pkg::M_READ;
                o_cmd.emit      = i_sts.out_free;
                o_cmd.emit_last = (r_ch == LAST_CH);
            end
            default: o_cmd.mode = stlr_pkg::M_SPIKE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stlr_pkg::S_CLEAR;
            r_clr   <= '0;
            r_idx   <= '0;
            r_ch    <= '0;
            r_drain <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                stlr_pkg::S_CLEAR: r_clr <= r_clr + 1'b1;
                stlr_pkg::S_IDLE: begin
                    r_idx <= '0;
                    r_ch  <= '0;
                end
                stlr_pkg::S_TICK, stlr_pkg::S_SWEEP: begin
                    r_idx   <= (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
                    r_drain <= 1'b0;
                end
                stlr_pkg::S_DRAIN: r_drain <= 1'b1;
                stlr_pkg::S_EMIT: begin
                    if (i_sts.out_free) begin
                        r_ch  <= r_ch + 1'b1;
                        r_idx <= '0;
                    end
                end
                default: r_drain <= 1'b0;
            endcase
        end
    end

    `STLR_ASSERT_RST(a_reset_clears, !i_rst_n |=> r_state == stlr_pkg::S_CLEAR)
    `STLR_ASSERT(a_spike_two_cycles, r_state == stlr_pkg::S_SPIKE |=> r_state == stlr_pkg::S_IDLE)
    `STLR_ASSERT(a_tick_starts_at_zero,
        w_accept && i_op == stlr_pkg::OP_TICK |=> r_state == stlr_pkg::S_TICK && r_idx == '0)
    `STLR_ASSERT(a_last_emit_ends_run,
        o_cmd.emit && o_cmd.emit_last |=> r_state == stlr_pkg::S_IDLE)

endmodule

[rtl/stlr_dp.sv]
// trace and weight stores, multiply-accumulate path and output register
// depends on stlr_pkg and stlr_ram
module stlr_dp #(
    parameter int NUM_INPUTS   = 64,
    parameter int NUM_CHANNELS = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  stlr_pkg::t_cmd        i_cmd,
    output stlr_pkg::t_sts        o_sts,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [23:0]           i_cfg_data,
    input  logic [5:0]            i_neuron_index,
    input  logic [5:0]            i_channel_index,
    input  logic signed [15:0]    i_weight_value,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [5:0]            o_channel,
    output logic signed [47:0]    o_command_value,
    output logic                  o_last_channel
);

    localparam int NI_W = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
    localparam int NC_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int AW   = NI_W + NC_W;
    localparam logic [15:0] W_RESET = 16'((16384 + NUM_INPUTS / 2) / NUM_INPUTS);

    logic [15:0]         r_decay;
    logic [23:0]         r_inc;
    logic [5:0]          r_n;
    logic                r_n_ok;
    logic                r_v1;
    stlr_pkg::t_mode     r_mode1;
    logic [NI_W-1:0]     r_addr1;
    logic                r_v2;
    logic signed [40:0]  r_prod;
    logic signed [47:0]  r_acc;
    logic                r_out_valid;
    logic [5:0]          r_out_ch;
    logic signed [47:0]  r_out_val;
    logic                r_out_last;

    logic                tr_we;
    logic [NI_W-1:0]     tr_waddr;
    logic [23:0]         tr_wdata;
    logic [NI_W-1:0]     tr_raddr;
    logic [23:0]         tr_rdata;
    logic                wt_we;
    logic [AW-1:0]       wt_waddr;
    logic [15:0]         wt_wdata;
    logic [AW-1:0]       wt_raddr;
    logic [15:0]         wt_rdata;
    logic [24:0]         w_sum;
    logic [39:0]         w_dec;
    logic signed [40:0]  w_prod;
    logic                w_ww_ok;

    assign w_sum  = {1'b0, tr_rdata} + {1'b0, r_inc};
    assign w_dec  = tr_rdata * r_decay;
    assign w_prod = $signed({1'b0, tr_rdata}) * $signed(wt_rdata);
    assign w_ww_ok = ({1'b0, i_neuron_index} < 7'(NUM_INPUTS))
                  && ({1'b0, i_channel_index} < 7'(NUM_CHANNELS));

    always_comb begin
        tr_we    = 1'b0;
        tr_waddr = r_addr1;
        tr_wdata = '0;
        if (i_cmd.clr_we) begin
            tr_we    = 1'b1;
            tr_waddr = i_cmd.clr_addr[NI_W-1:0];
        end else if (r_v1 && r_mode1 == stlr_pkg::M_SPIKE) begin
            tr_we    = r_n_ok;
            tr_waddr = r_n[NI_W-1:0];
            tr_wdata = w_sum[24] ? stlr_pkg::TRACE_MAX : w_sum[23:0];
        end else if (r_v1 && r_mode1 == stlr_pkg::M_TICK) begin
            tr_we    = 1'b1;
            tr_wdata = w_dec[39:16];
        end
    end

    assign tr_raddr = (i_cmd.mode == stlr_pkg::M_SPIKE) ? r_n[NI_W-1:0]
                                                        : i_cmd.idx[NI_W-1:0];

    always_comb begin
        if (i_cmd.clr_we) begin
            wt_we    = 1'b1;
            wt_waddr = i_cmd.clr_addr[AW-1:0];
            wt_wdata = W_RESET;
        end else begin
            wt_we    = i_cmd.wwrite && w_ww_ok;
            wt_waddr = {i_channel_index[NC_W-1:0], i_neuron_index[NI_W-1:0]};
            wt_wdata = i_weight_value;
        end
    end

    assign wt_raddr = {i_cmd.ch[NC_W-1:0], i_cmd.idx[NI_W-1:0]};

    stlr_ram #(.WIDTH(24), .DEPTH(2 ** NI_W)) u_trace_ram (
        .i_clk   (i_clk),
        .i_we    (tr_we),
        .i_waddr (tr_waddr),
        .i_wdata (tr_wdata),
        .i_re    (i_cmd.tr_rd),
        .i_raddr (tr_raddr),
        .o_rdata (tr_rdata)
    );

    stlr_ram #(.WIDTH(16), .DEPTH(2 ** AW)) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (wt_we),
        .i_waddr (wt_waddr),
        .i_wdata (wt_wdata),
        .i_re    (i_cmd.wt_rd),
        .i_raddr (wt_raddr),
        .o_rdata (wt_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay     <= stlr_pkg::DECAY_RESET;
            r_inc       <= stlr_pkg::INC_RESET;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_index == stlr_pkg::CFG_DECAY) r_decay <= i_cfg_data[15:0];
            if (i_cfg_we && i_cfg_index == stlr_pkg::CFG_INC)   r_inc   <= i_cfg_data;
            r_v1 <= i_cmd.tr_rd;
            r_v2 <= r_v1 && (r_mode1 == stlr_pkg::M_READ);
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode1 <= i_cmd.mode;
        r_addr1 <= i_cmd.idx[NI_W-1:0];
        r_prod  <= w_prod;
        if (i_cmd.latch) begin
            r_n    <= i_neuron_index;
            r_n_ok <= ({1'b0, i_neuron_index} < 7'(NUM_INPUTS));
        end
        if (i_cmd.latch || i_cmd.emit) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + {{7{r_prod[40]}}, r_prod};
        end
        if (i_cmd.emit) begin
            r_out_ch   <= i_cmd.ch;
            r_out_val  <= r_acc;
            r_out_last <= i_cmd.emit_last;
        end
    end

    assign o_sts.out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_channel       = r_out_ch;
    assign o_command_value = r_out_val;
    assign o_last_channel  = r_out_last;

endmodule

[rtl/spike_trace_linear_readout_top.sv]
// Decaying spike-trace store with a linear weighted readout. A decay tick
// walks the traces one per cycle through the single trace ram read port,
// and a readout walks the traces channel by channel through the one
// multiply-accumulate lane and is held while a full output is stalled.
// After reset a clearing pass loads the stores; configuration writes
// are taken during it and at any idle time.
// depends on stlr_pkg, stlr_ctrl, stlr_dp and stlr_ram
module spike_trace_linear_readout_top #(
    parameter int NUM_INPUTS   = 64,
    parameter int NUM_CHANNELS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_op,
    input  logic [5:0]         i_neuron_index,
    input  logic [5:0]         i_channel_index,
    input  logic signed [15:0] i_weight_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [5:0]         o_channel,
    output logic signed [47:0] o_command_value,
    output logic               o_last_channel
);

    stlr_pkg::t_cmd cmd;
    stlr_pkg::t_sts sts;

    stlr_ctrl #(.NUM_INPUTS(NUM_INPUTS), .NUM_CHANNELS(NUM_CHANNELS)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    stlr_dp #(.NUM_INPUTS(NUM_INPUTS), .NUM_CHANNELS(NUM_CHANNELS)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_neuron_index  (i_neuron_index),
        .i_channel_index (i_channel_index),
        .i_weight_value  (i_weight_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_channel       (o_channel),
        .o_command_value (o_command_value),
        .o_last_channel  (o_last_channel)
    );

endmodule

[dv/spike_trace_linear_readout_top_tb.sv]
`timescale 1ns / 1ps
// testbench for spike_trace_linear_readout_top: a directed table of requests, then
// random phases under several register settings, readouts checked against a predictor
// or typed sums; depends on stlr_pkg and the rtl of spike_trace_linear_readout_top
module spike_trace_linear_readout_top_tb;

    localparam int NI = 64;
    localparam int NC = 4;
    localparam int IDX_W   = stlr_pkg::IDX_W;
    localparam int SUM_W   = stlr_pkg::SUM_W;
    localparam int WGT_W   = stlr_pkg::WGT_W;
    localparam int TRACE_W = stlr_pkg::TRACE_W;
    localparam int CFG_W   = stlr_pkg::CFG_W;
    localparam logic [1:0] CFG_SPARE_A = 2'd2;
    localparam logic [1:0] CFG_SPARE_B = 2'd3;
    localparam int HOLD_CYCLES   = 600;
    localparam int SETTLE_CYCLES = 320;
    localparam int PHASE_ITEMS   = 65;
    localparam int CYCLE_LIMIT   = 1000000;

    typedef struct {
        logic [IDX_W-1:0]        channel;
        logic signed [SUM_W-1:0] value;
        logic                    last;
    } t_readout;

    typedef struct {
        bit                      is_cfg;
        stlr_pkg::t_op           op;
        logic [IDX_W-1:0]        neuron;
        logic [IDX_W-1:0]        chan;
        logic signed [WGT_W-1:0] wgt;
        bit                      typed;
        logic signed [SUM_W-1:0] sum;
        logic [1:0]              cfg_idx;
        logic [CFG_W-1:0]        cfg_data;
    } t_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [1:0]              i_cfg_index = '0;
    logic [23:0]             i_cfg_data = '0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic [1:0]              i_op = '0;
    logic [5:0]              i_neuron_index = '0;
    logic [5:0]              i_channel_index = '0;
    logic signed [15:0]      i_weight_value = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic [5:0]              o_channel;
    logic signed [47:0]      o_command_value;
    logic                    o_last_channel;

    logic [TRACE_W-1:0]      trace_m [NI];
    logic signed [WGT_W-1:0] weight_m [NC][NI];
    logic [15:0]             decay_m;
    logic [CFG_W-1:0]        inc_m;
    t_readout                pending_readouts [$];
    t_readout                want;
    t_row                    plan [$];

    int errors = 0;
    int cycles = 0;
    int hold_seq = 0;
    int hold_seen = 0;
    int stall_left = 0;
    int rx_roll = 0;
    bit rx_quiet = 1'b0;
    bit tx_quiet = 1'b0;

    always #1 i_clk = ~i_clk;

    spike_trace_linear_readout_top #(
        .NUM_INPUTS  (NI),
        .NUM_CHANNELS(NC)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_neuron_index (i_neuron_index),
        .i_channel_index(i_channel_index),
        .i_weight_value (i_weight_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_channel      (o_channel),
        .o_command_value(o_command_value),
        .o_last_channel (o_last_channel)
    );

    function automatic void reset_model();
        for (int j = 0; j < NI; j++) begin
            trace_m[j] = '0;
            for (int c = 0; c < NC; c++) begin
                weight_m[c][j] = WGT_W'((16384 + NI / 2) / NI);
            end
        end
        decay_m = stlr_pkg::DECAY_RESET;
        inc_m   = stlr_pkg::INC_RESET;
    endfunction

    function automatic void apply_config(logic [1:0] idx, logic [CFG_W-1:0] data);
        if (idx == stlr_pkg::CFG_DECAY) begin
            decay_m = data[15:0];
        end else if (idx == stlr_pkg::CFG_INC) begin
            inc_m = data;
        end
    endfunction

    function automatic void step_traces(stlr_pkg::t_op op, logic [IDX_W-1:0] n,
                                        logic [IDX_W-1:0] ch, logic signed [WGT_W-1:0] w);
        logic [TRACE_W:0]        raised;
        logic [39:0]             prod;
        logic signed [SUM_W-1:0] acc;
        logic signed [SUM_W-1:0] tr48;
        logic signed [SUM_W-1:0] w48;
        t_readout                rd;
        case (op)
            stlr_pkg::OP_SPIKE: begin
                if (n < NI) begin
                    raised = {1'b0, trace_m[n]} + {1'b0, inc_m};
                    trace_m[n] = raised[TRACE_W] ? stlr_pkg::TRACE_MAX
                                                 : raised[TRACE_W-1:0];
                end
            end
            stlr_pkg::OP_TICK: begin
                for (int j = 0; j < NI; j++) begin
                    prod = {16'd0, trace_m[j]} * {24'd0, decay_m};
                    trace_m[j] = prod[39:16];
                end
            end
            stlr_pkg::OP_WWRITE: begin
                if (n < NI && ch < NC) begin
                    weight_m[ch][n] = w;
                end
            end
            default: begin
                for (int c = 0; c < NC; c++) begin
                    acc = '0;
                    for (int j = 0; j < NI; j++) begin
                        tr48 = {24'd0, trace_m[j]};
                        w48  = weight_m[c][j];
                        acc  = acc + tr48 * w48;
                    end
                    rd = '{channel: IDX_W'(c), value: acc, last: (c == NC - 1)};
                    pending_readouts = {pending_readouts, rd};
                end
            end
        endcase
    endfunction

    task automatic send_request(input stlr_pkg::t_op op, input logic [IDX_W-1:0] n,
                                input logic [IDX_W-1:0] ch, input logic signed [WGT_W-1:0] w,
                                input bit typed, input logic signed [SUM_W-1:0] sum);
        int gap;
        int r;
        t_readout rd;
        r = $urandom_range(0, 99);
        if (tx_quiet || r < 50) begin
            gap = 0;
        end else if (r < 90) begin
            gap = $urandom_range(1, 3);
        end else begin
            gap = $urandom_range(10, 40);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_op            <= op;
        i_neuron_index  <= n;
        i_channel_index <= ch;
        i_weight_value  <= w;
        i_in_valid      <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        if (typed) begin
            for (int c = 0; c < NC; c++) begin
                rd = '{channel: IDX_W'(c), value: sum, last: (c == NC - 1)};
                pending_readouts = {pending_readouts, rd};
            end
        end else begin
            step_traces(op, n, ch, w);
        end
    endtask

    // drop the request line and let the block run dry
    task automatic quiesce();
        i_in_valid <= 1'b0;
        while (pending_readouts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        apply_config(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic add_item(input stlr_pkg::t_op op, input logic [IDX_W-1:0] n,
                            input logic [IDX_W-1:0] ch, input logic signed [WGT_W-1:0] w);
        t_row row;
        row = '{is_cfg: 1'b0, op: op, neuron: n, chan: ch, wgt: w, typed: 1'b0,
                sum: '0, cfg_idx: '0, cfg_data: '0};
        plan = {plan, row};
    endtask

    task automatic add_read_typed(input logic signed [SUM_W-1:0] sum);
        t_row row;
        row = '{is_cfg: 1'b0, op: stlr_pkg::OP_READ, neuron: 6'd0, chan: 6'd0, wgt: '0,
                typed: 1'b1, sum: sum, cfg_idx: '0, cfg_data: '0};
        plan = {plan, row};
    endtask

    task automatic add_cfg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
        t_row row;
        row = '{is_cfg: 1'b1, op: stlr_pkg::OP_SPIKE, neuron: '0, chan: '0, wgt: '0,
                typed: 1'b0, sum: '0, cfg_idx: idx, cfg_data: data};
        plan = {plan, row};
    endtask

    // result side: checking and back-pressure
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_readouts.size() == 0) begin
                $error("unexpected readout: channel %0d value %0d", o_channel, o_command_value);
                errors++;
            end else begin
                want = pending_readouts.pop_front();
                if (o_channel !== want.channel) begin
                    $error("channel: expected %0d, got %0d", want.channel, o_channel);
                    errors++;
                end
                if (o_command_value !== want.value) begin
                    $error("command_value: expected %0d, got %0d", want.value,
                           o_command_value);
                    errors++;
                end
                if (o_last_channel !== want.last) begin
                    $error("last_channel: expected %0d, got %0d", want.last, o_last_channel);
                    errors++;
                end
            end
        end
        if (hold_seq != hold_seen) begin
            hold_seen  <= hold_seq;
            stall_left = HOLD_CYCLES;
        end
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else if (rx_quiet) begin
            i_out_stall <= 1'b0;
        end else begin
            rx_roll = $urandom_range(0, 99);
            if (rx_roll < 55) begin
                i_out_stall <= 1'b0;
            end else if (rx_roll < 93) begin
                i_out_stall <= 1'b1;
                stall_left = $urandom_range(0, 3);
            end else begin
                i_out_stall <= 1'b1;
                stall_left = $urandom_range(10, 60);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int r;
        int done;
        stlr_pkg::t_op op;
        logic [IDX_W-1:0] n;
        logic [IDX_W-1:0] ch;
        logic signed [WGT_W-1:0] w;
        logic [15:0] decay;
        logic [CFG_W-1:0] inc;

        reset_model();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // registers beyond the second do nothing
        add_cfg(CFG_SPARE_A, 24'hFFFFFF);
        add_cfg(CFG_SPARE_B, 24'h000000);
        add_read_typed(48'sd0);
        add_item(stlr_pkg::OP_SPIKE, 6'd5, 6'd63, -16'sd1);
        add_read_typed(48'sd16777216);
        add_item(stlr_pkg::OP_SPIKE, 6'd63, 6'd0, 16'sd0);
        add_item(stlr_pkg::OP_WWRITE, 6'd63, 6'd0, -16'sd32768);
        add_item(stlr_pkg::OP_WWRITE, 6'd0, 6'd3, 16'sd32767);
        add_item(stlr_pkg::OP_WWRITE, 6'd5, 6'd3, 16'sd32767);
        // row out of range, ignored
        add_item(stlr_pkg::OP_WWRITE, 6'd1, 6'd4, 16'sd1000);
        add_item(stlr_pkg::OP_WWRITE, 6'd63, 6'd63, -16'sd1);
        add_item(stlr_pkg::OP_READ, 6'd63, 6'd63, -16'sd32768);
        add_item(stlr_pkg::OP_TICK, 6'd42, 6'd21, 16'sh5555);
        add_item(stlr_pkg::OP_READ, 6'd0, 6'd0, 16'sd0);
        // zero decay with the upper data bits set, full increment saturates
        add_cfg(stlr_pkg::CFG_DECAY, 24'hFF0000);
        add_cfg(stlr_pkg::CFG_INC, 24'hFFFFFF);
        add_item(stlr_pkg::OP_SPIKE, 6'd10, 6'd0, 16'sd0);
        add_item(stlr_pkg::OP_SPIKE, 6'd10, 6'd0, 16'sd0);
        add_item(stlr_pkg::OP_SPIKE, 6'd0, 6'd0, 16'sd0);
        add_item(stlr_pkg::OP_READ, 6'd0, 6'd0, 16'sd0);
        add_item(stlr_pkg::OP_TICK, 6'd0, 6'd0, 16'sd0);
        add_read_typed(48'sd0);
        add_cfg(stlr_pkg::CFG_DECAY, 24'h00FFFF);
        add_item(stlr_pkg::OP_SPIKE, 6'd20, 6'd0, 16'sd0);
        add_item(stlr_pkg::OP_SPIKE, 6'd20, 6'd0, 16'sd0);
        add_item(stlr_pkg::OP_TICK, 6'd0, 6'd0, 16'sd0);
        add_item(stlr_pkg::OP_READ, 6'd0, 6'd0, 16'sd0);
        add_cfg(stlr_pkg::CFG_INC, 24'h000000);
        add_item(stlr_pkg::OP_SPIKE, 6'd20, 6'd0, 16'sd0);
        add_item(stlr_pkg::OP_READ, 6'd0, 6'd0, 16'sd0);

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                quiesce();
                cfg_write(plan[i].cfg_idx, plan[i].cfg_data);
            end else begin
                send_request(plan[i].op, plan[i].neuron, plan[i].chan, plan[i].wgt,
                             plan[i].typed, plan[i].sum);
            end
        end

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    decay = 16'($urandom_range(60000, 65535));
                    inc   = 24'($urandom_range(0, 1 << 20));
                end
                1: begin
                    decay = 16'hFFFF;
                    inc   = 24'hFFFFFF;
                end
                2: begin
                    decay = 16'h0000;
                    inc   = 24'($urandom_range(0, 24'hFFFFFF));
                end
                3: begin
                    decay = 16'($urandom);
                    inc   = 24'($urandom);
                end
                4: begin
                    decay = 16'($urandom_range(50000, 65535));
                    inc   = 24'($urandom_range(0, 1 << 18));
                end
                default: begin
                    decay = 16'($urandom_range(0, 65535));
                    inc   = 24'($urandom_range(1 << 16, 1 << 22));
                end
            endcase
            quiesce();
            cfg_write(stlr_pkg::CFG_DECAY, {8'($urandom), decay});
            cfg_write(stlr_pkg::CFG_INC, inc);

            if (phase == 4) begin
                // long hold-off on the result side while readouts keep coming
                hold_seq <= hold_seq + 1;
                tx_quiet = 1'b1;
                repeat (10) send_request(stlr_pkg::OP_READ, 6'($urandom), 6'($urandom),
                                         16'($urandom), 1'b0, '0);
                tx_quiet = 1'b0;
            end
            if (phase == 5) begin
                rx_quiet <= 1'b1;
                tx_quiet = 1'b1;
            end

            done = 0;
            while (done < PHASE_ITEMS) begin
                r = $urandom_range(0, 99);
                if (r < 35) begin
                    op = stlr_pkg::OP_SPIKE;
                end else if (r < 50) begin
                    op = stlr_pkg::OP_TICK;
                end else if (r < 70) begin
                    op = stlr_pkg::OP_READ;
                end else begin
                    op = stlr_pkg::OP_WWRITE;
                end
                n = 6'($urandom);
                if (op == stlr_pkg::OP_WWRITE && $urandom_range(0, 3) != 0) begin
                    ch = 6'($urandom_range(0, NC - 1));
                end else begin
                    ch = 6'($urandom);
                end
                case ($urandom_range(0, 9))
                    0: w = -16'sd32768;
                    1: w = 16'sd32767;
                    default: w = 16'($urandom);
                endcase
                send_request(op, n, ch, w, 1'b0, '0);
                if (!(op == stlr_pkg::OP_WWRITE && ch >= NC)) begin
                    done++;
                end
            end
            tx_quiet = 1'b0;
        end

        quiesce();
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/stlr_pkg.sv
rtl/stlr_ram.sv
rtl/stlr_ctrl.sv
rtl/stlr_dp.sv
rtl/spike_trace_linear_readout_top.sv
dv/spike_trace_linear_readout_top_tb.sv
